>>> src/mcdf_pkg.sv
// shared types, constants and direction decode for the depth-first maze carver
`default_nettype none
package mcdf_pkg;

	localparam int MAX_SIDE    = 63;
	localparam int SIDE_W      = 6;
	localparam int ROOM_SIDE   = (MAX_SIDE - 1) / 2;
	localparam int STACK_CAP   = ROOM_SIDE * ROOM_SIDE + 1;
	localparam int LVL_W       = $clog2(STACK_CAP + 1);
	localparam int STACK_DEPTH = 2 ** LVL_W;
	localparam int MAP_ROWS    = 2 ** SIDE_W;
	localparam int ROW_W       = 2 ** SIDE_W;
	localparam int SHUF_W      = 5;
	localparam int NUM_ORDERS  = 24;

	localparam logic [1:0] OP_STEP    = 2'd0;
	localparam logic [1:0] OP_RESTART = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;

	localparam logic [1:0] KIND_CARVED   = 2'd0;
	localparam logic [1:0] KIND_READ     = 2'd1;
	localparam logic [1:0] KIND_FINISHED = 2'd2;
	localparam logic [1:0] KIND_INVALID  = 2'd3;

	localparam logic [1:0] CODE_WALL  = 2'd0;
	localparam logic [1:0] CODE_OPEN  = 2'd1;
	localparam logic [1:0] CODE_ENTRY = 2'd2;
	localparam logic [1:0] CODE_EXIT  = 2'd3;

	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	localparam logic [SIDE_W-1:0] SIDE_RESET = 6'd21;

	typedef struct packed {
		logic [SIDE_W-1:0] r;
		logic [SIDE_W-1:0] c;
		logic [SHUF_W-1:0] order;
		logic [2:0]        tried;
	} frame_t;

	// k-th direction of the lexicographic permutation with index order
	function automatic logic [1:0] order_dir(input logic [SHUF_W-1:0] order,
		input logic [1:0] k);
		logic [1:0] pool [4];
		logic [1:0] sel [4];
		logic [2:0] rem;
		logic [1:0] d;
		pool[0] = DIR_UP;
		pool[1] = DIR_DOWN;
		pool[2] = DIR_LEFT;
		pool[3] = DIR_RIGHT;
		// first pick by compare against multiples of six
		sel[0] = (order >= 5'd18) ? 2'd3 : (order >= 5'd12) ? 2'd2
			: (order >= 5'd6) ? 2'd1 : 2'd0;
		rem    = 3'(order - 5'(sel[0]) * 5'd6);
		sel[1] = rem[2:1];
		sel[2] = {1'b0, rem[0]};
		sel[3] = 2'd0;
		d = DIR_UP;
		for (int i = 0; i < 4; i++) begin
			if (2'(i) == k) begin
				d = pool[sel[i]];
			end
			for (int j = 0; j < 3; j++) begin
				if (2'(j) >= sel[i]) begin
					pool[j] = pool[j + 1];
				end
			end
		end
		return d;
	endfunction

endpackage
`default_nettype wire

>>> src/mcdf_ram.sv
// generic single-write, single-read synchronous ram with registered read data
`default_nettype none
module mcdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> src/maze_carver_depth_first.sv
// top level of the depth-first maze carver: control sequencer, grid map and walk stack
`default_nettype none
// Recursive-backtracker maze carver. The grid (one bit per cell) lives in a 64-row
// by 64-bit synchronous ram, one row per grid row; the walk stack lives in a second
// ram of frames, with the top frame held in registers. One transaction is worked at a
// time. After reset, and on every accepted restart, a clearing pass writes all 64 map
// rows while no input transaction is taken; a restart answers once it is done. A read
// waits on one map ram read; a step on a finished maze goes straight to the output. A
// step skips each direction that falls outside the grid, reads the map row for each
// other one, backtracks with one stack ram read per level, and on a carve writes the
// new room's row, reading and writing the wall's row too when it is another row. Each
// result sits in an output register, so the next transaction is taken while it waits.
// Configuration writes are always ready; the size registers only take effect at the
// next restart.
module maze_carver_depth_first (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [5:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [4:0]  shuffle_index,
	input  wire logic [5:0]  row,
	input  wire logic [5:0]  column,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [1:0]  kind,
	output logic      [5:0]  cell_row,
	output logic      [5:0]  cell_col,
	output logic      [5:0]  wall_row,
	output logic      [5:0]  wall_col,
	output logic      [1:0]  cell_code
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_TRY, S_POPWAIT, S_CHK,
		S_WALLRD, S_WALLWR, S_READWAIT, S_OUT
	} state_t;

	localparam int SW = mcdf_pkg::SIDE_W;
	localparam int LW = mcdf_pkg::LVL_W;
	localparam int RW = mcdf_pkg::ROW_W;

	state_t state_q;

	// size registers and the size latched at restart
	logic [SW-1:0] grid_w_q, grid_h_q, live_w_q, live_h_q;

	// top of the walk stack
	mcdf_pkg::frame_t top_q;
	logic             fresh_q;
	logic [LW-1:0]    lvl_q;
	logic             finished_q;
	logic             ends_open_q;

	// clearing pass
	logic [SW-1:0] clr_q;
	logic          seed_q;

	// candidate room and wall
	logic [SW-1:0] nr_q, nc_q, wr_q, wc_q;
	logic          vert_q;

	// read request
	logic [SW-1:0] rd_r_q, rd_c_q;

	// pending result
	logic [1:0]    res_kind_q, res_code_q;
	logic [SW-1:0] res_cr_q, res_cc_q, res_wr_q, res_wc_q;

	// map and stack ram ports
	logic          map_we;
	logic [SW-1:0] map_waddr, map_raddr;
	logic [RW-1:0] map_wdata, map_rdata;
	logic          stk_we;
	logic [LW-1:0] stk_waddr, stk_raddr;
	mcdf_pkg::frame_t stk_wdata, stk_rdata;

	// direction decode for the top frame
	logic [1:0]    dir;
	logic [SW:0]   r_ext, c_ext, h_lim, w_lim;
	logic          cand_ok;
	logic [SW-1:0] cand_nr, cand_nc, cand_wr, cand_wc;
	logic [RW-1:0] row_set;
	logic [LW-1:0] lvl_dec;
	logic [4:0]    shuf_adj;
	logic          size_ok;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);

	assign r_ext   = {1'b0, top_q.r};
	assign c_ext   = {1'b0, top_q.c};
	assign h_lim   = {1'b0, live_h_q} - 7'd1;
	assign w_lim   = {1'b0, live_w_q} - 7'd1;
	assign dir     = mcdf_pkg::order_dir(top_q.order, top_q.tried[1:0]);
	assign lvl_dec = lvl_q - LW'(1);
	assign shuf_adj = (shuffle_index >= 5'(mcdf_pkg::NUM_ORDERS))
		? shuffle_index - 5'(mcdf_pkg::NUM_ORDERS) : shuffle_index;
	assign size_ok = (grid_w_q >= 6'd5) && grid_w_q[0] && (grid_h_q >= 6'd5) && grid_h_q[0];

	// neighbor two cells away and the wall between, with the interior bounds test
	always_comb begin
		cand_nr = top_q.r;
		cand_nc = top_q.c;
		cand_wr = top_q.r;
		cand_wc = top_q.c;
		cand_ok = 1'b0;
		case (dir)
			mcdf_pkg::DIR_UP: begin
				cand_nr = top_q.r - 6'd2;
				cand_wr = top_q.r - 6'd1;
				cand_ok = (top_q.r > 6'd2) && ((r_ext - 7'd2) < h_lim);
			end
			mcdf_pkg::DIR_DOWN: begin
				cand_nr = top_q.r + 6'd2;
				cand_wr = top_q.r + 6'd1;
				cand_ok = (r_ext + 7'd2) < h_lim;
			end
			mcdf_pkg::DIR_LEFT: begin
				cand_nc = top_q.c - 6'd2;
				cand_wc = top_q.c - 6'd1;
				cand_ok = (top_q.c > 6'd2) && ((c_ext - 7'd2) < w_lim);
			end
			mcdf_pkg::DIR_RIGHT: begin
				cand_nc = top_q.c + 6'd2;
				cand_wc = top_q.c + 6'd1;
				cand_ok = (c_ext + 7'd2) < w_lim;
			end
			default: cand_ok = 1'b0;
		endcase
		// the row and column also bound against the cell range of the grid
		if (r_ext < 7'd1 || c_ext < 7'd1) begin
			cand_ok = 1'b0;
		end
	end

	// ram port steering
	always_comb begin
		map_we    = 1'b0;
		map_waddr = clr_q;
		map_wdata = '0;
		map_raddr = cand_nr;
		stk_we    = 1'b0;
		stk_waddr = lvl_dec;
		stk_wdata = top_q;
		stk_raddr = lvl_dec - LW'(1);
		row_set   = map_rdata;
		case (state_q)
			S_CLEAR: begin
				map_we    = 1'b1;
				map_waddr = clr_q;
				// restart opens room (1,1) on its way through row 1
				if (seed_q && clr_q == 6'd1) begin
					map_wdata = RW'(2);
				end
			end
			S_IDLE: begin
				map_raddr = row;
			end
			S_CHK: begin
				row_set[nc_q] = 1'b1;
				if (!vert_q) begin
					row_set[wc_q] = 1'b1;
				end
				if (!map_rdata[nc_q]) begin
					map_we    = 1'b1;
					map_waddr = nr_q;
					map_wdata = row_set;
					stk_we    = !vert_q;
				end
			end
			S_WALLRD: begin
				map_raddr = wr_q;
			end
			S_WALLWR: begin
				row_set[wc_q] = 1'b1;
				map_we    = 1'b1;
				map_waddr = wr_q;
				map_wdata = row_set;
				stk_we    = 1'b1;
			end
			default: begin
				map_we = 1'b0;
			end
		endcase
	end

	mcdf_ram #(.WIDTH(RW), .DEPTH(mcdf_pkg::MAP_ROWS)) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	mcdf_ram #(.WIDTH($bits(mcdf_pkg::frame_t)), .DEPTH(mcdf_pkg::STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			grid_w_q    <= mcdf_pkg::SIDE_RESET;
			grid_h_q    <= mcdf_pkg::SIDE_RESET;
			live_w_q    <= mcdf_pkg::SIDE_RESET;
			live_h_q    <= mcdf_pkg::SIDE_RESET;
			fresh_q     <= 1'b0;
			lvl_q       <= '0;
			finished_q  <= 1'b1;
			ends_open_q <= 1'b0;
			clr_q       <= '0;
			seed_q      <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == mcdf_pkg::CFG_WIDTH) begin
					grid_w_q <= cfg_data;
				end else begin
					grid_h_q <= cfg_data;
				end
			end
			// the output register empties once its result is taken, unless a new one is loaded
			if (out_valid && out_ready && state_q != S_OUT) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 6'd1;
					if (clr_q == 6'(mcdf_pkg::MAP_ROWS - 1)) begin
						state_q <= seed_q ? S_OUT : S_IDLE;
					end
				end
				S_IDLE: begin
					res_kind_q <= mcdf_pkg::KIND_INVALID;
					res_cr_q   <= '0;
					res_cc_q   <= '0;
					res_wr_q   <= '0;
					res_wc_q   <= '0;
					res_code_q <= mcdf_pkg::CODE_WALL;
					if (in_valid) begin
						case (op)
							mcdf_pkg::OP_STEP: begin
								if (finished_q) begin
									res_kind_q <= mcdf_pkg::KIND_FINISHED;
									state_q    <= S_OUT;
								end else begin
									if (fresh_q) begin
										top_q.order <= shuf_adj;
										top_q.tried <= 3'd0;
										fresh_q     <= 1'b0;
									end
									state_q <= S_TRY;
								end
							end
							mcdf_pkg::OP_RESTART: begin
								if (size_ok) begin
									live_w_q    <= grid_w_q;
									live_h_q    <= grid_h_q;
									top_q.r     <= 6'd1;
									top_q.c     <= 6'd1;
									top_q.order <= '0;
									top_q.tried <= 3'd0;
									fresh_q     <= 1'b1;
									lvl_q       <= LW'(1);
									finished_q  <= 1'b0;
									ends_open_q <= 1'b0;
									clr_q       <= '0;
									seed_q      <= 1'b1;
									res_kind_q  <= mcdf_pkg::KIND_CARVED;
									res_cr_q    <= 6'd1;
									res_cc_q    <= 6'd1;
									state_q     <= S_CLEAR;
								end else begin
									state_q <= S_OUT;
								end
							end
							mcdf_pkg::OP_READ: begin
								rd_r_q <= row;
								rd_c_q <= column;
								if (row >= live_h_q || column >= live_w_q) begin
									state_q <= S_OUT;
								end else begin
									state_q <= S_READWAIT;
								end
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_READWAIT: begin
					res_kind_q <= mcdf_pkg::KIND_READ;
					res_cr_q   <= rd_r_q;
					res_cc_q   <= rd_c_q;
					// entry and exit are only open once the maze is done
					if (ends_open_q && rd_r_q == 6'd1 && rd_c_q == 6'd0) begin
						res_code_q <= mcdf_pkg::CODE_ENTRY;
					end else if (ends_open_q && rd_r_q == live_h_q - 6'd2
						&& rd_c_q == live_w_q - 6'd1) begin
						res_code_q <= mcdf_pkg::CODE_EXIT;
					end else begin
						res_code_q <= map_rdata[rd_c_q] ? mcdf_pkg::CODE_OPEN
							: mcdf_pkg::CODE_WALL;
					end
					state_q <= S_OUT;
				end
				S_TRY: begin
					if (top_q.tried == 3'd4) begin
						// room exhausted: backtrack one level
						lvl_q <= lvl_dec;
						if (lvl_dec == '0) begin
							finished_q  <= 1'b1;
							ends_open_q <= 1'b1;
							res_kind_q  <= mcdf_pkg::KIND_FINISHED;
							state_q     <= S_OUT;
						end else begin
							state_q <= S_POPWAIT;
						end
					end else begin
						top_q.tried <= top_q.tried + 3'd1;
						nr_q   <= cand_nr;
						nc_q   <= cand_nc;
						wr_q   <= cand_wr;
						wc_q   <= cand_wc;
						vert_q <= (dir == mcdf_pkg::DIR_UP) || (dir == mcdf_pkg::DIR_DOWN);
						if (cand_ok && lvl_q < LW'(mcdf_pkg::STACK_CAP)) begin
							state_q <= S_CHK;
						end
					end
				end
				S_POPWAIT: begin
					top_q   <= stk_rdata;
					state_q <= S_TRY;
				end
				S_CHK: begin
					if (map_rdata[nc_q]) begin
						state_q <= S_TRY;
					end else begin
						res_kind_q <= mcdf_pkg::KIND_CARVED;
						res_cr_q   <= nr_q;
						res_cc_q   <= nc_q;
						res_wr_q   <= wr_q;
						res_wc_q   <= wc_q;
						if (vert_q) begin
							state_q <= S_WALLRD;
						end else begin
							top_q.r     <= nr_q;
							top_q.c     <= nc_q;
							top_q.tried <= 3'd0;
							fresh_q     <= 1'b1;
							lvl_q       <= lvl_q + LW'(1);
							state_q     <= S_OUT;
						end
					end
				end
				S_WALLRD: begin
					state_q <= S_WALLWR;
				end
				S_WALLWR: begin
					top_q.r     <= nr_q;
					top_q.c     <= nc_q;
					top_q.tried <= 3'd0;
					fresh_q     <= 1'b1;
					lvl_q       <= lvl_q + LW'(1);
					state_q     <= S_OUT;
				end
				S_OUT: begin
					seed_q <= 1'b0;
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						kind      <= res_kind_q;
						cell_row  <= res_cr_q;
						cell_col  <= res_cc_q;
						wall_row  <= res_wr_q;
						wall_col  <= res_wc_q;
						cell_code <= res_code_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// stack depth stays within the room count plus one
	assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q <= LW'(mcdf_pkg::STACK_CAP))
		else $error("walk stack level beyond capacity");

	// a finished maze has an empty stack
	assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |-> (lvl_q == '0))
		else $error("finished with frames left on the stack");

	// entry and exit only open on a finished maze
	assert property (@(posedge clk) disable iff (!arst_n)
		ends_open_q |-> finished_q)
		else $error("entry and exit open while carving");

	// a map check always follows a direction try
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHK) |-> ($past(state_q) == S_TRY))
		else $error("map check without a direction try");

endmodule
`default_nettype wire
